// ===== design/pngcp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the PNG chunk stream parser.
// No dependencies; imported by pngcp_chunk_eval and png_chunk_stream_parser.

package pngcp_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_SIG,
    PH_LEN,
    PH_TYPE,
    PH_DATA,
    PH_CRC,
    PH_DONE
  } phase_t;

  // Result status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_BAD_SIG     = 4'd1;
  localparam logic [3:0] ST_BAD_LEN     = 4'd2;
  localparam logic [3:0] ST_BAD_COLOUR  = 4'd3;
  localparam logic [3:0] ST_BAD_DEPTH   = 4'd4;
  localparam logic [3:0] ST_BAD_COMPR   = 4'd5;
  localparam logic [3:0] ST_BAD_FILTER  = 4'd6;
  localparam logic [3:0] ST_BAD_ILACE   = 4'd7;
  localparam logic [3:0] ST_REPEAT_IHDR = 4'd8;

  // Chunk type codes, first file byte in the top byte
  localparam logic [31:0] T_IHDR = 32'h4948_4452;
  localparam logic [31:0] T_GAMA = 32'h6741_4D41;
  localparam logic [31:0] T_CHRM = 32'h6348_524D;
  localparam logic [31:0] T_TIME = 32'h7449_4D45;
  localparam logic [31:0] T_IEND = 32'h4945_4E44;
  localparam logic [31:0] T_BKGD = 32'h624B_4744;

  // Fixed chunk lengths
  localparam logic [31:0] LEN_IHDR = 32'd13;
  localparam logic [31:0] LEN_GAMA = 32'd4;
  localparam logic [31:0] LEN_CHRM = 32'd32;
  localparam logic [31:0] LEN_TIME = 32'd7;
  localparam logic [31:0] LEN_IEND = 32'd0;
  localparam logic [31:0] LEN_BKGD_GRAY = 32'd2;
  localparam logic [31:0] LEN_BKGD_RGB  = 32'd6;
  localparam logic [31:0] LEN_BKGD_PAL  = 32'd1;

  // Colour type codes
  localparam logic [7:0] COL_GRAY       = 8'd0;
  localparam logic [7:0] COL_RGB        = 8'd2;
  localparam logic [7:0] COL_PALETTE    = 8'd3;
  localparam logic [7:0] COL_GRAY_ALPHA = 8'd4;
  localparam logic [7:0] COL_RGBA       = 8'd6;

  // Byte counts of the framing fields
  localparam logic [31:0] SIG_BYTES   = 32'd8;
  localparam logic [31:0] FIELD_BYTES = 32'd4;
  localparam int          HDR_BYTES   = 13;

  // Captured IHDR data bytes, byte 0 first in file order
  typedef logic [HDR_BYTES-1:0][7:0] hdr_t;

  // One result word
  typedef struct packed {
    logic [31:0] chunk_type;
    logic [31:0] chunk_length;
    logic [3:0]  status;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [7:0]  bit_depth;
    logic [7:0]  colour_kind;
    logic [7:0]  interlace_kind;
    logic [2:0]  channels;
    logic        stream_done;
  } res_t;

  // PNG signature byte at a given position
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'd137;
      3'd1:    val = 8'd80;
      3'd2:    val = 8'd78;
      3'd3:    val = 8'd71;
      3'd4:    val = 8'd13;
      3'd5:    val = 8'd10;
      3'd6:    val = 8'd26;
      3'd7:    val = 8'd10;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== design/pngcp_chunk_eval.sv =====
`timescale 1ns / 1ps
// Chunk result builder: status checks and IHDR field decode for a closed chunk.
// Depends on pngcp_pkg.

module pngcp_chunk_eval import pngcp_pkg::*; (
  input  logic        checks_enabled,
  input  logic [31:0] type_r,
  input  logic [31:0] length_r,
  input  hdr_t        hdr_r,
  input  logic        seen_header_r,
  input  logic [7:0]  saved_colour_r,
  output res_t        res
);

  logic       is_ihdr;
  logic [7:0] colour;
  logic [7:0] depth;
  logic       colour_ok;
  logic       depth_ok;
  logic [2:0] chan;
  logic [3:0] status;

  assign is_ihdr = (type_r == T_IHDR);
  assign colour  = hdr_r[9];
  assign depth   = hdr_r[8];

  always_comb begin
    colour_ok = 1'b1;
    depth_ok  = 1'b1;
    chan      = 3'd0;
    case (colour)
      COL_GRAY: begin
        chan     = 3'd1;
        depth_ok = (depth == 8'd1) || (depth == 8'd2) || (depth == 8'd4) ||
                   (depth == 8'd8) || (depth == 8'd16);
      end
      COL_PALETTE: begin
        depth_ok = (depth == 8'd1) || (depth == 8'd2) || (depth == 8'd4) ||
                   (depth == 8'd8);
      end
      COL_RGB: begin
        chan     = 3'd3;
        depth_ok = (depth == 8'd8) || (depth == 8'd16);
      end
      COL_GRAY_ALPHA: begin
        chan     = 3'd2;
        depth_ok = (depth == 8'd8) || (depth == 8'd16);
      end
      COL_RGBA: begin
        chan     = 3'd4;
        depth_ok = (depth == 8'd8) || (depth == 8'd16);
      end
      default: colour_ok = 1'b0;
    endcase
  end

  // Length error wins, then repeat, then the IHDR fields in order
  always_comb begin
    status = ST_OK;
    case (type_r)
      T_IHDR: begin
        if (length_r != LEN_IHDR)      status = ST_BAD_LEN;
        else if (seen_header_r)        status = ST_REPEAT_IHDR;
        else if (!colour_ok)           status = ST_BAD_COLOUR;
        else if (!depth_ok)            status = ST_BAD_DEPTH;
        else if (hdr_r[10] != 8'd0)    status = ST_BAD_COMPR;
        else if (hdr_r[11] != 8'd0)    status = ST_BAD_FILTER;
        else if (hdr_r[12] > 8'd1)     status = ST_BAD_ILACE;
      end
      T_GAMA: if (length_r != LEN_GAMA) status = ST_BAD_LEN;
      T_CHRM: if (length_r != LEN_CHRM) status = ST_BAD_LEN;
      T_TIME: if (length_r != LEN_TIME) status = ST_BAD_LEN;
      T_IEND: if (length_r != LEN_IEND) status = ST_BAD_LEN;
      T_BKGD: begin
        case (saved_colour_r)
          COL_GRAY, COL_GRAY_ALPHA: if (length_r != LEN_BKGD_GRAY) status = ST_BAD_LEN;
          COL_RGB, COL_RGBA:        if (length_r != LEN_BKGD_RGB)  status = ST_BAD_LEN;
          COL_PALETTE:              if (length_r != LEN_BKGD_PAL)  status = ST_BAD_LEN;
          default:                  status = ST_OK;
        endcase
      end
      default: status = ST_OK;
    endcase
  end

  always_comb begin
    res              = '0;
    res.chunk_type   = type_r;
    res.chunk_length = length_r;
    res.status       = checks_enabled ? status : ST_OK;
    if (is_ihdr) begin
      res.image_width    = {hdr_r[0], hdr_r[1], hdr_r[2], hdr_r[3]};
      res.image_height   = {hdr_r[4], hdr_r[5], hdr_r[6], hdr_r[7]};
      res.bit_depth      = depth;
      res.colour_kind    = colour;
      res.interlace_kind = hdr_r[12];
      res.channels       = chan;
    end
    res.stream_done = (type_r == T_IEND);
  end

endmodule

// ===== design/png_chunk_stream_parser.sv =====
`timescale 1ns / 1ps
// PNG chunk stream parser top level: byte framing, IHDR capture, output skid.
// Depends on pngcp_pkg and pngcp_chunk_eval.

// Takes a PNG file one byte per word and frames it: 8-byte signature, then per
// chunk a big-endian length, a 4-byte type, the data and a 4-byte CRC (counted,
// not checked). One result word per chunk is registered when its last CRC
// byte is taken, carrying type, length, status and, for IHDR, the decoded
// header fields. A bad signature gives one result with status 1 after the 8th
// byte. After IEND or a bad signature, bytes are swallowed until in_file_start
// marks a new file; in_file_start also restarts parsing mid-file. Throughput is
// one byte per clock: all per-byte work is a single pass of logic into the
// state registers, and the result lands in an output register backed by a
// one-word skid register, so in_ready drops only when both hold an untaken
// result. Reset leaves checks enabled and needs no clearing pass.
// cfg_wr_data sets checks_enabled; write it only while the parser is idle.

module png_chunk_stream_parser import pngcp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_file_start,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_chunk_type,
  output logic [31:0] out_chunk_length,
  output logic [3:0]  out_status,
  output logic [31:0] out_image_width,
  output logic [31:0] out_image_height,
  output logic [7:0]  out_bit_depth,
  output logic [7:0]  out_colour_kind,
  output logic [7:0]  out_interlace_kind,
  output logic [2:0]  out_channels,
  output logic        out_stream_done
);

  // parser state
  logic        checks_en_r;
  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] typ_r, typ_nxt;
  hdr_t        hdr_r, hdr_nxt;
  logic        seen_r, seen_nxt;
  logic [7:0]  saved_col_r, saved_col_nxt;
  logic        sig_ok_r, sig_ok_nxt;

  // output stage
  logic        out_valid_r, skid_valid_r;
  res_t        out_res_r, skid_res_r;

  // per-byte working values (state after an optional restart)
  logic        in_acc;
  phase_t      ph;
  logic [31:0] cnt, cnt_inc, len, typ, typ_shift;
  hdr_t        hdr;
  logic        seen, sig_ok, sig_match;
  logic [7:0]  saved_col;
  logic        emit_sig, emit_chunk, push;
  res_t        chunk_res, sig_res, new_res;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = !skid_valid_r;

  // in_file_start restarts everything except the config bit
  assign ph        = in_file_start ? PH_SIG : phase_r;
  assign cnt       = in_file_start ? 32'd0  : cnt_r;
  assign len       = in_file_start ? 32'd0  : len_r;
  assign typ       = in_file_start ? 32'd0  : typ_r;
  assign hdr       = in_file_start ? hdr_t'('0) : hdr_r;
  assign seen      = in_file_start ? 1'b0   : seen_r;
  assign saved_col = in_file_start ? 8'd0   : saved_col_r;
  assign sig_ok    = in_file_start ? 1'b1   : sig_ok_r;

  assign cnt_inc   = cnt + 32'd1;
  assign typ_shift = {typ[23:0], in_data_byte};
  assign sig_match = (in_data_byte == sig_byte(cnt[2:0]));

  // next phase
  always_comb begin
    phase_nxt = ph;
    case (ph)
      PH_SIG:  if (cnt_inc == SIG_BYTES) phase_nxt = (sig_ok && sig_match) ? PH_LEN : PH_DONE;
      PH_LEN:  if (cnt_inc == FIELD_BYTES) phase_nxt = PH_TYPE;
      PH_TYPE: if (cnt_inc == FIELD_BYTES) phase_nxt = (len == 32'd0) ? PH_CRC : PH_DATA;
      PH_DATA: if (cnt_inc == len) phase_nxt = PH_CRC;
      PH_CRC:  if (cnt_inc == FIELD_BYTES) phase_nxt = (typ == T_IEND) ? PH_DONE : PH_LEN;
      PH_DONE: phase_nxt = PH_DONE;
      default: phase_nxt = PH_DONE;
    endcase
  end

  // datapath and result strobes
  always_comb begin
    cnt_nxt       = cnt;
    len_nxt       = len;
    typ_nxt       = typ;
    hdr_nxt       = hdr;
    seen_nxt      = seen;
    saved_col_nxt = saved_col;
    sig_ok_nxt    = sig_ok;
    emit_sig      = 1'b0;
    emit_chunk    = 1'b0;
    case (ph)
      PH_SIG: begin
        if (!sig_match) sig_ok_nxt = 1'b0;
        cnt_nxt = cnt_inc;
        if (cnt_inc == SIG_BYTES) begin
          cnt_nxt  = 32'd0;
          emit_sig = !(sig_ok && sig_match);
        end
      end
      PH_LEN: begin
        len_nxt = {len[23:0], in_data_byte};
        cnt_nxt = (cnt_inc == FIELD_BYTES) ? 32'd0 : cnt_inc;
      end
      PH_TYPE: begin
        typ_nxt = typ_shift;
        cnt_nxt = cnt_inc;
        if (cnt_inc == FIELD_BYTES) begin
          cnt_nxt = 32'd0;
          if (typ_shift == T_IHDR) hdr_nxt = '0;
        end
      end
      PH_DATA: begin
        if ((typ == T_IHDR) && (cnt < 32'(HDR_BYTES))) begin
          for (int i = 0; i < HDR_BYTES; i++) begin
            if (cnt[3:0] == 4'(i)) hdr_nxt[i] = in_data_byte;
          end
        end
        cnt_nxt = (cnt_inc == len) ? 32'd0 : cnt_inc;
      end
      PH_CRC: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc == FIELD_BYTES) begin
          cnt_nxt    = 32'd0;
          emit_chunk = 1'b1;
          if (typ == T_IHDR) begin
            saved_col_nxt = hdr[9];
            seen_nxt      = 1'b1;
          end
        end
      end
      PH_DONE: cnt_nxt = cnt;
      default: cnt_nxt = cnt;
    endcase
  end

  // chunk result from the current registers; only used in the CRC phase,
  // where no restart is in progress
  pngcp_chunk_eval u_eval (
    .checks_enabled (checks_en_r),
    .type_r         (typ_r),
    .length_r       (len_r),
    .hdr_r          (hdr_r),
    .seen_header_r  (seen_r),
    .saved_colour_r (saved_col_r),
    .res            (chunk_res)
  );

  always_comb begin
    sig_res             = '0;
    sig_res.status      = ST_BAD_SIG;
    sig_res.stream_done = 1'b1;
  end

  assign new_res = emit_sig ? sig_res : chunk_res;
  assign push    = in_acc && (emit_sig || emit_chunk);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      checks_en_r <= 1'b1;
      phase_r     <= PH_SIG;
      cnt_r       <= '0;
      len_r       <= '0;
      typ_r       <= '0;
      hdr_r       <= '0;
      seen_r      <= 1'b0;
      saved_col_r <= '0;
      sig_ok_r    <= 1'b1;
    end else begin
      if (cfg_wr_en) checks_en_r <= cfg_wr_data;
      if (in_acc) begin
        phase_r     <= phase_nxt;
        cnt_r       <= cnt_nxt;
        len_r       <= len_nxt;
        typ_r       <= typ_nxt;
        hdr_r       <= hdr_nxt;
        seen_r      <= seen_nxt;
        saved_col_r <= saved_col_nxt;
        sig_ok_r    <= sig_ok_nxt;
      end
    end
  end

  // output register plus one-word skid; push never coincides with a full skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) out_res_r <= skid_res_r;
      else if (push)    out_res_r <= new_res;
    end else if (push) begin
      skid_res_r <= new_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_chunk_type     = out_res_r.chunk_type;
  assign out_chunk_length   = out_res_r.chunk_length;
  assign out_status         = out_res_r.status;
  assign out_image_width    = out_res_r.image_width;
  assign out_image_height   = out_res_r.image_height;
  assign out_bit_depth      = out_res_r.bit_depth;
  assign out_colour_kind    = out_res_r.colour_kind;
  assign out_interlace_kind = out_res_r.interlace_kind;
  assign out_channels       = out_res_r.channels;
  assign out_stream_done    = out_res_r.stream_done;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a word while output register is empty");

  a_data_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (len_r != 32'd0))
    else $error("data phase entered with zero length");

  a_done_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE && !in_file_start) |-> !push)
    else $error("result produced after stream end");

  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && new_res.stream_done) |=> (phase_r == PH_DONE))
    else $error("stream end result without entering done phase");

endmodule

// ===== tb/png_chunk_stream_checker.sv =====
`timescale 1ns / 1ps
// Checker for png_chunk_stream_parser: follows the accepted byte words, predicts
// each chunk report and compares it with the result channel. Uses pngcp_pkg.

module png_chunk_stream_checker import pngcp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_file_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_chunk_type,
  input  logic [31:0] out_chunk_length,
  input  logic [3:0]  out_status,
  input  logic [31:0] out_image_width,
  input  logic [31:0] out_image_height,
  input  logic [7:0]  out_bit_depth,
  input  logic [7:0]  out_colour_kind,
  input  logic [7:0]  out_interlace_kind,
  input  logic [2:0]  out_channels,
  input  logic        out_stream_done,
  output int          bad_fields,
  output int          reports_due
);

  localparam logic [0:7][7:0] PNG_MAGIC =
    {8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10};

  // parser mirror
  logic        checks_on;
  phase_t      ph;
  logic [31:0] cnt;
  logic [31:0] len;
  logic [31:0] typ;
  hdr_t        hdr;
  logic        seen_ihdr;
  logic [7:0]  colour_q;
  logic        sig_good;

  res_t chunk_reports_q[$];

  task automatic new_file();
    ph        = PH_SIG;
    cnt       = '0;
    len       = '0;
    typ       = '0;
    hdr       = '0;
    seen_ihdr = 1'b0;
    colour_q  = '0;
    sig_good  = 1'b1;
  endtask

  function automatic logic [2:0] channels_of(input logic [7:0] c);
    case (c)
      COL_GRAY:       return 3'd1;
      COL_RGB:        return 3'd3;
      COL_GRAY_ALPHA: return 3'd2;
      COL_RGBA:       return 3'd4;
      default:        return 3'd0;
    endcase
  endfunction

  function automatic logic depth_legal(input logic [7:0] c, input logic [7:0] d);
    case (c)
      COL_GRAY:    return d == 8'd1 || d == 8'd2 || d == 8'd4 || d == 8'd8 || d == 8'd16;
      COL_PALETTE: return d == 8'd1 || d == 8'd2 || d == 8'd4 || d == 8'd8;
      COL_RGB, COL_GRAY_ALPHA, COL_RGBA: return d == 8'd8 || d == 8'd16;
      default:     return 1'b1;
    endcase
  endfunction

  // length check first, then repeat, then the IHDR fields in file order
  function automatic logic [3:0] chunk_verdict();
    case (typ)
      T_IHDR: begin
        if (len != LEN_IHDR) return ST_BAD_LEN;
        if (seen_ihdr) return ST_REPEAT_IHDR;
        if (channels_of(hdr[9]) == 3'd0 && hdr[9] != COL_PALETTE) return ST_BAD_COLOUR;
        if (!depth_legal(hdr[9], hdr[8])) return ST_BAD_DEPTH;
        if (hdr[10] != 8'd0) return ST_BAD_COMPR;
        if (hdr[11] != 8'd0) return ST_BAD_FILTER;
        if (hdr[12] > 8'd1) return ST_BAD_ILACE;
        return ST_OK;
      end
      T_GAMA: return (len != LEN_GAMA) ? ST_BAD_LEN : ST_OK;
      T_CHRM: return (len != LEN_CHRM) ? ST_BAD_LEN : ST_OK;
      T_TIME: return (len != LEN_TIME) ? ST_BAD_LEN : ST_OK;
      T_IEND: return (len != LEN_IEND) ? ST_BAD_LEN : ST_OK;
      T_BKGD: begin
        case (colour_q)
          COL_GRAY, COL_GRAY_ALPHA: return (len != LEN_BKGD_GRAY) ? ST_BAD_LEN : ST_OK;
          COL_RGB, COL_RGBA:        return (len != LEN_BKGD_RGB) ? ST_BAD_LEN : ST_OK;
          COL_PALETTE:              return (len != LEN_BKGD_PAL) ? ST_BAD_LEN : ST_OK;
          default:                  return ST_OK;
        endcase
      end
      default: return ST_OK;
    endcase
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic s);
    res_t r;
    r = '0;
    if (s) new_file();
    case (ph)
      PH_SIG: begin
        if (b != PNG_MAGIC[cnt[2:0]]) sig_good = 1'b0;
        cnt++;
        if (cnt >= SIG_BYTES) begin
          cnt = '0;
          if (sig_good) begin
            ph = PH_LEN;
          end else begin
            ph            = PH_DONE;
            r.status      = ST_BAD_SIG;
            r.stream_done = 1'b1;
            chunk_reports_q.push_back(r);
          end
        end
      end
      PH_LEN: begin
        len = {len[23:0], b};
        cnt++;
        if (cnt >= FIELD_BYTES) begin
          cnt = '0;
          ph  = PH_TYPE;
        end
      end
      PH_TYPE: begin
        typ = {typ[23:0], b};
        cnt++;
        if (cnt >= FIELD_BYTES) begin
          cnt = '0;
          if (typ == T_IHDR) hdr = '0;
          ph = (len == 32'd0) ? PH_CRC : PH_DATA;
        end
      end
      PH_DATA: begin
        if (typ == T_IHDR && cnt < HDR_BYTES) hdr[cnt[3:0]] = b;
        cnt++;
        if (cnt == len) begin
          cnt = '0;
          ph  = PH_CRC;
        end
      end
      PH_CRC: begin
        cnt++;
        if (cnt >= FIELD_BYTES) begin
          cnt            = '0;
          r.chunk_type   = typ;
          r.chunk_length = len;
          r.status       = checks_on ? chunk_verdict() : ST_OK;
          if (typ == T_IHDR) begin
            r.image_width    = {hdr[0], hdr[1], hdr[2], hdr[3]};
            r.image_height   = {hdr[4], hdr[5], hdr[6], hdr[7]};
            r.bit_depth      = hdr[8];
            r.colour_kind    = hdr[9];
            r.interlace_kind = hdr[12];
            r.channels       = channels_of(hdr[9]);
            colour_q         = hdr[9];
            seen_ihdr        = 1'b1;
          end
          r.stream_done = (typ == T_IEND);
          chunk_reports_q.push_back(r);
          ph = (typ == T_IEND) ? PH_DONE : PH_LEN;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      if (bad_fields < 10)
        $display("%0t %s mismatch: expected %h, got %h", $time, name, want, got);
      bad_fields++;
    end
  endtask

  task automatic compare_report();
    res_t want;
    if (chunk_reports_q.size() == 0) begin
      if (bad_fields < 10)
        $display("%0t unexpected chunk report: type %h length %h status %0d",
                 $time, out_chunk_type, out_chunk_length, out_status);
      bad_fields++;
    end else begin
      want = chunk_reports_q.pop_front();
      check_field("chunk_type", want.chunk_type, out_chunk_type);
      check_field("chunk_length", want.chunk_length, out_chunk_length);
      check_field("status", want.status, out_status);
      check_field("image_width", want.image_width, out_image_width);
      check_field("image_height", want.image_height, out_image_height);
      check_field("bit_depth", want.bit_depth, out_bit_depth);
      check_field("colour_kind", want.colour_kind, out_colour_kind);
      check_field("interlace_kind", want.interlace_kind, out_interlace_kind);
      check_field("channels", want.channels, out_channels);
      check_field("stream_done", want.stream_done, out_stream_done);
    end
  endtask

  // results are popped before the byte of this edge is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      checks_on = 1'b1;
      new_file();
      chunk_reports_q.delete();
    end else begin
      if (cfg_wr_en) checks_on = cfg_wr_data;
      if (out_valid && out_ready) compare_report();
      if (in_valid && in_ready) take_byte(in_data_byte, in_file_start);
    end
    reports_due <= chunk_reports_q.size();
  end

endmodule

// ===== tb/tb_png_chunk_stream_parser.sv =====
`timescale 1ns / 1ps
// Testbench top for png_chunk_stream_parser: builds PNG byte streams, drives the
// byte channel and config, stalls the result side. Needs pngcp_pkg and the checker.

module tb_png_chunk_stream_parser;
  import pngcp_pkg::*;

  // Chunk types the block has no rule for
  localparam logic [31:0] T_IDAT = 32'h4944_4154;
  localparam logic [31:0] T_TEXT = 32'h7445_5874;

  // Cycles with no word moving on either channel before the run is called hung.
  // The limit is many times the longest gap or stall that idle_len can draw.
  localparam int WATCHDOG_LIMIT = 2000;

  // Ways to spoil an otherwise clean IHDR
  typedef enum int {
    HDR_CLEAN,
    HDR_BAD_COLOUR,
    HDR_BAD_DEPTH,
    HDR_BAD_COMPR,
    HDR_BAD_FILTER,
    HDR_BAD_ILACE
  } hdr_fault_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_file_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_chunk_type;
  logic [31:0] out_chunk_length;
  logic [3:0]  out_status;
  logic [31:0] out_image_width;
  logic [31:0] out_image_height;
  logic [7:0]  out_bit_depth;
  logic [7:0]  out_colour_kind;
  logic [7:0]  out_interlace_kind;
  logic [2:0]  out_channels;
  logic        out_stream_done;

  int mismatch_count;
  int reports_due;

  // stimulus bookkeeping
  logic [8:0] file_bytes[$];   // {file_start, byte}, in file order
  logic [7:0] gen_colour = 8'd0; // colour of the last IHDR built, picks bKGD sizes
  bit         fast_sender = 1'b0;
  int         bytes_sent = 0;
  int         idle_cycles = 0;
  int         stall_left = 0;
  int         calm_left = 0;

  always #1 clk = ~clk;

  png_chunk_stream_parser u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_file_start      (in_file_start),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_chunk_type     (out_chunk_type),
    .out_chunk_length   (out_chunk_length),
    .out_status         (out_status),
    .out_image_width    (out_image_width),
    .out_image_height   (out_image_height),
    .out_bit_depth      (out_bit_depth),
    .out_colour_kind    (out_colour_kind),
    .out_interlace_kind (out_interlace_kind),
    .out_channels       (out_channels),
    .out_stream_done    (out_stream_done)
  );

  png_chunk_stream_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_file_start      (in_file_start),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_chunk_type     (out_chunk_type),
    .out_chunk_length   (out_chunk_length),
    .out_status         (out_status),
    .out_image_width    (out_image_width),
    .out_image_height   (out_image_height),
    .out_bit_depth      (out_bit_depth),
    .out_colour_kind    (out_colour_kind),
    .out_interlace_kind (out_interlace_kind),
    .out_channels       (out_channels),
    .out_stream_done    (out_stream_done),
    .bad_fields         (mismatch_count),
    .reports_due        (reports_due)
  );

  // Gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Result side: random stalls, broken up by calm stretches of steady ready
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (calm_left != 0) begin
        calm_left <= calm_left - 1;
      end else if ($urandom_range(0, 199) == 0) begin
        calm_left <= $urandom_range(50, 300);
      end else begin
        stall_left <= idle_len();
      end
    end
  end

  // Watchdog on channel activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stream build

  task automatic add_byte(input logic [7:0] b);
    file_bytes.push_back({1'b0, b});
  endtask

  // big-endian, as every PNG length field
  task automatic add_word32(input logic [31:0] v);
    for (int i = 3; i >= 0; i--) add_byte(v[8*i +: 8]);
  endtask

  // Signature; a bad one has one byte flipped somewhere. file_start rides on
  // the first byte unless with_start is clear.
  task automatic add_signature(input bit bad, input bit with_start);
    int pos;
    logic [7:0] b;
    pos = bad ? $urandom_range(0, 7) : 8;
    if (with_start) gen_colour = COL_GRAY;
    for (int i = 0; i < 8; i++) begin
      b = sig_byte(3'(i));
      if (i == pos) b = b ^ 8'($urandom_range(1, 255));
      file_bytes.push_back({with_start && i == 0, b});
    end
  endtask

  // Length, type, random data and random CRC (never checked by the block)
  task automatic add_chunk(input logic [31:0] typ, input logic [31:0] n);
    add_word32(n);
    add_word32(typ);
    repeat (n) add_byte(8'($urandom));
    repeat (4) add_byte(8'($urandom));
  endtask

  // IHDR with given fields; n shorter than 13 truncates, longer pads with noise
  task automatic add_ihdr(input logic [31:0] n, input logic [31:0] w, input logic [31:0] h,
                          input logic [7:0] d, input logic [7:0] c, input logic [7:0] cm,
                          input logic [7:0] f, input logic [7:0] il);
    logic [103:0] body;
    body = {w, h, d, c, cm, f, il};
    gen_colour = (n >= 32'd10) ? c : COL_GRAY;
    add_word32(n);
    add_word32(T_IHDR);
    for (int i = 0; i < n; i++) begin
      if (i < HDR_BYTES) add_byte(body[103 - 8*i -: 8]);
      else add_byte(8'($urandom));
    end
    repeat (4) add_byte(8'($urandom));
  endtask

  // Legal colour/depth pair, then at most one field spoiled
  task automatic add_random_ihdr(input logic [31:0] n, input hdr_fault_e fault);
    logic [7:0] c, d, cm, f, il;
    case ($urandom_range(0, 4))
      0:       c = COL_GRAY;
      1:       c = COL_RGB;
      2:       c = COL_PALETTE;
      3:       c = COL_GRAY_ALPHA;
      default: c = COL_RGBA;
    endcase
    d = 8'd1 << $urandom_range(0, 4);
    if (c == COL_PALETTE && d == 8'd16) d = 8'd8;
    if (c != COL_GRAY && c != COL_PALETTE && d < 8'd8) d = 8'd8;
    cm = 8'd0;
    f  = 8'd0;
    il = 8'($urandom_range(0, 1));
    case (fault)
      HDR_BAD_COLOUR: c  = 8'($urandom);
      HDR_BAD_DEPTH:  d  = 8'($urandom);
      HDR_BAD_COMPR:  cm = 8'($urandom_range(1, 255));
      HDR_BAD_FILTER: f  = 8'($urandom_range(1, 255));
      HDR_BAD_ILACE:  il = 8'($urandom_range(2, 255));
      default: ;
    endcase
    add_ihdr(n, $urandom, $urandom, d, c, cm, f, il);
  endtask

  function automatic logic [31:0] bkgd_len(input logic [7:0] c);
    case (c)
      COL_GRAY, COL_GRAY_ALPHA: return LEN_BKGD_GRAY;
      COL_RGB, COL_RGBA:        return LEN_BKGD_RGB;
      COL_PALETTE:              return LEN_BKGD_PAL;
      default:                  return $urandom_range(0, 8);
    endcase
  endfunction

  // One body chunk; a quarter of them get a random length instead of the right one
  task automatic add_random_chunk();
    logic [31:0] typ, n;
    bit right;
    right = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 6))
      0: begin typ = T_GAMA; n = LEN_GAMA; end
      1: begin typ = T_CHRM; n = LEN_CHRM; end
      2: begin typ = T_TIME; n = LEN_TIME; end
      3: begin typ = T_BKGD; n = bkgd_len(gen_colour); end
      4: begin typ = T_IHDR; n = LEN_IHDR; end
      5: begin typ = $urandom; n = $urandom_range(0, 12); end
      default: begin typ = T_IDAT; n = $urandom_range(0, 40); end
    endcase
    if (!right) n = $urandom_range(0, 40);
    if (typ == T_IHDR) add_random_ihdr(n, HDR_CLEAN);
    else add_chunk(typ, n);
  endtask

  // Mostly well-formed files with random content; some broken or cut short
  task automatic build_random_file();
    int pick;
    add_signature($urandom_range(0, 11) == 0, $urandom_range(0, 15) != 0);
    pick = $urandom_range(0, 9);
    if (pick < 7) add_random_ihdr(LEN_IHDR, HDR_CLEAN);
    else if (pick == 7) add_random_ihdr(LEN_IHDR, hdr_fault_e'($urandom_range(1, 5)));
    else if (pick == 8) add_random_ihdr($urandom_range(0, 20), HDR_CLEAN);
    repeat ($urandom_range(0, 5)) add_random_chunk();
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      add_chunk(T_IEND, LEN_IEND);
    end else if (pick == 7) begin
      add_chunk(T_IEND, $urandom_range(1, 3));
    end else if (pick == 8) begin
      // dropped mid-chunk; the next file start takes over
      add_word32($urandom_range(1, 40));
      add_word32($urandom);
      repeat ($urandom_range(0, 10)) add_byte(8'($urandom));
    end
    // trailing junk: swallowed after IEND or a bad signature, parsed as chunk bytes otherwise
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
  endtask

  // ---------------------------------------------------------------- driving

  // Valid stays up across back-to-back words; it is lowered only for a gap
  task automatic drive_byte(input logic [7:0] b, input logic s);
    int gap;
    gap = fast_sender ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_file_start <= s;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic feed_bytes();
    logic [8:0] w;
    while (file_bytes.size() != 0) begin
      w = file_bytes.pop_front();
      drive_byte(w[7:0], w[8]);
    end
  endtask

  // Sender holds off until every predicted report is out, then idles on
  // for a chunk report still in flight inside the block
  task automatic drain_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_checks(input logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    int base_bytes;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // First file right after reset with no file_start: every chunk kind that
    // has a length rule, extreme IHDR width/height, a zero-length chunk, then
    // bytes that must be swallowed after IEND.
    add_signature(1'b0, 1'b0);
    add_ihdr(LEN_IHDR, 32'hFFFF_FFFF, 32'd0, 8'd16, COL_GRAY, 8'd0, 8'd0, 8'd1);
    add_chunk(T_GAMA, LEN_GAMA);
    add_chunk(T_BKGD, LEN_BKGD_GRAY);
    add_chunk(T_TEXT, 32'd0);
    add_chunk(T_CHRM, LEN_CHRM);
    add_chunk(T_TIME, LEN_TIME);
    add_chunk(T_IEND, LEN_IEND);
    add_byte(8'hFF);
    add_byte(8'h00);

    // Bad signature, then swallowed bytes
    add_signature(1'b1, 1'b1);
    repeat (3) add_byte(8'($urandom));

    // Restart in the middle of the signature
    file_bytes.push_back({1'b1, sig_byte(3'd0)});
    add_byte(sig_byte(3'd1));
    add_byte(8'h00);
    add_signature(1'b0, 1'b1);
    // colour type 5 is not legal; saved colour 5 turns off the bKGD rule
    add_ihdr(LEN_IHDR, 32'd1, 32'd1, 8'd8, 8'd5, 8'd0, 8'd0, 8'd0);
    add_chunk(T_BKGD, 32'd9);
    // repeated IHDR still moves the saved colour to palette
    add_ihdr(LEN_IHDR, 32'd640, 32'd480, 8'd8, COL_PALETTE, 8'd0, 8'd0, 8'd0);
    add_chunk(T_BKGD, LEN_BKGD_GRAY);
    add_ihdr(32'd12, 32'd5, 32'd6, 8'd8, COL_RGB, 8'd0, 8'd0, 8'd0);
    add_chunk(T_IEND, 32'd1);

    // One field error per file, each file abandoned by the next restart
    add_signature(1'b0, 1'b1);
    add_ihdr(LEN_IHDR, 32'd2, 32'd2, 8'd4, COL_RGB, 8'd0, 8'd0, 8'd0);
    add_chunk(T_BKGD, LEN_BKGD_RGB);
    add_signature(1'b0, 1'b1);
    add_ihdr(LEN_IHDR, 32'd3, 32'd3, 8'd8, COL_GRAY_ALPHA, 8'd1, 8'd0, 8'd0);
    add_chunk(T_BKGD, LEN_BKGD_GRAY);
    add_signature(1'b0, 1'b1);
    add_ihdr(LEN_IHDR, 32'd4, 32'd4, 8'd8, COL_RGBA, 8'd0, 8'd255, 8'd0);
    add_signature(1'b0, 1'b1);
    add_ihdr(LEN_IHDR, 32'd0, 32'hFFFF_FFFF, 8'd1, COL_PALETTE, 8'd0, 8'd0, 8'd2);
    add_chunk(T_BKGD, LEN_BKGD_PAL);
    // longest possible length: can never finish, cut by a restart
    add_word32(32'hFFFF_FFFF);
    add_word32(T_TEXT);
    repeat (5) add_byte(8'($urandom));
    add_signature(1'b0, 1'b1);
    add_ihdr(32'd20, 32'd7, 32'd9, 8'd16, COL_RGBA, 8'd0, 8'd0, 8'd1);
    add_chunk(T_IEND, LEN_IEND);
    feed_bytes();

    // Checks off: length and field errors report ok, bad signature still does not
    drain_reports();
    write_checks(1'b0);
    add_signature(1'b0, 1'b1);
    add_ihdr(32'd5, 32'd1, 32'd1, 8'd3, 8'd7, 8'd1, 8'd1, 8'd9);
    add_chunk(T_GAMA, 32'd0);
    add_chunk(T_IEND, 32'd4);
    add_signature(1'b1, 1'b1);
    feed_bytes();
    drain_reports();
    write_checks(1'b1);

    // A short run of random files on top of the directed streams
    base_bytes = bytes_sent;
    while ((bytes_sent - base_bytes) < 100) begin
      if ($urandom_range(0, 5) == 0) begin
        drain_reports();
        if ($urandom_range(0, 1) == 0) write_checks(1'($urandom_range(0, 1)));
      end
      fast_sender = ($urandom_range(0, 4) == 0);
      build_random_file();
      feed_bytes();
    end

    // Let the last reports out and give stray ones time to show
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_due != 0);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== png_chunk_stream_parser.f =====
design/pngcp_pkg.sv
design/pngcp_chunk_eval.sv
design/png_chunk_stream_parser.sv
tb/png_chunk_stream_checker.sv
tb/tb_png_chunk_stream_parser.sv
